// ===== rtl/islsq_pkg.sv =====
package islsq_pkg;

    // timing constants in ms, then colour levels and the palette size
    localparam logic [31:0] HOUR_MS          = 32'd3600000;
    localparam logic [31:0] CAROUSEL_STEP_MS = 32'd900;
    localparam logic [31:0] SALUTE_STEP_MS   = 32'd1500;
    localparam logic [31:0] SALUTE_LEN_MS    = 32'd4500;
    localparam logic [31:0] BLINK_LEN_MS     = 32'd600;
    localparam logic [31:0] BLINK_SLOT_MS    = 32'd200;
    localparam logic [31:0] BLINK_SLOT2_MS   = 32'd400;
    localparam logic [31:0] BEAT_PERIOD_MS   = 32'd10000;
    localparam logic [7:0]  DIM_RED          = 8'd24;
    localparam logic [7:0]  FULL             = 8'd255;
    localparam int          PALETTE_SIZE     = 12;

    localparam logic [15:0] LIMIT_RESET      = 16'd1200;

    // config register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NODE_ID        = 1'b0,
        REG_PRESENCE_LIMIT = 1'b1
    } t_reg_idx;

    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 24;

    // (since / 900) % 3 is taken from since mod 2700; 32-bit values are first
    // folded at bit 16 to a narrow value with the same residue
    localparam longint CAR_PERIOD = 3 * 900;
    localparam longint CAR_FOLD   = 65536 % CAR_PERIOD;
    localparam int     CAR_X_W    = 26;
    localparam int     CAR_SHIFT  = CAR_X_W + 12;
    localparam int     CAR_M_W    = 27;
    localparam int     CAR_Q_W    = 15;
    localparam int     CAR_R_W    = 12;
    localparam int     CAR_P_W    = CAR_X_W + CAR_M_W;
    localparam logic [CAR_M_W-1:0] CAR_RECIP =
        CAR_M_W'(((64'd1 << CAR_SHIFT) + 64'(CAR_PERIOD) - 64'd1) / 64'(CAR_PERIOD));

    localparam longint BEAT_PERIOD = 10000;
    localparam longint BEAT_FOLD   = 65536 % BEAT_PERIOD;
    localparam int     BEAT_X_W    = 29;
    localparam int     BEAT_SHIFT  = BEAT_X_W + 14;
    localparam int     BEAT_M_W    = 30;
    localparam int     BEAT_Q_W    = 16;
    localparam int     BEAT_R_W    = 14;
    localparam int     BEAT_P_W    = BEAT_X_W + BEAT_M_W;
    localparam logic [BEAT_M_W-1:0] BEAT_RECIP =
        BEAT_M_W'(((64'd1 << BEAT_SHIFT) + 64'(BEAT_PERIOD) - 64'd1) / 64'(BEAT_PERIOD));

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    typedef struct packed {
        logic [15:0] prox_closest_mm;
        logic        prox_valid;
        logic [15:0] tof_depth_mm;
        logic        tof_valid;
        logic        supply_good;
        logic [31:0] now_ms;
    } t_item;

    typedef enum logic [3:0] {
        K_FIXED     = 4'b0001,
        K_CAROUSEL  = 4'b0010,
        K_SIGNATURE = 4'b0100,
        K_BEAT      = 4'b1000
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        t_rgb                 fixed;
        logic [CAR_X_W-1:0]   car_x;
        logic [BEAT_X_W-1:0]  beat_x;
    } t_stage1;

    typedef struct packed {
        t_kind                kind;
        t_rgb                 fixed;
        logic [CAR_X_W-1:0]   car_x;
        logic [BEAT_X_W-1:0]  beat_x;
        logic [CAR_Q_W-1:0]   car_q;
        logic [BEAT_Q_W-1:0]  beat_q;
    } t_stage2;

    typedef struct packed {
        logic in_valid;
        logic advance;
        logic salute_started;
    } t_front_stat;

    function automatic t_rgb mk_rgb(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b);
        t_rgb c;
        c.red   = r;
        c.green = g;
        c.blue  = b;
        return c;
    endfunction

    function automatic t_rgb palette_rgb(input logic [3:0] idx);
        t_rgb c;
        case (idx)
            4'd0:    c = mk_rgb(8'd255, 8'd0,   8'd0);
            4'd1:    c = mk_rgb(8'd255, 8'd96,  8'd0);
            4'd2:    c = mk_rgb(8'd255, 8'd200, 8'd0);
            4'd3:    c = mk_rgb(8'd128, 8'd255, 8'd0);
            4'd4:    c = mk_rgb(8'd0,   8'd255, 8'd0);
            4'd5:    c = mk_rgb(8'd0,   8'd255, 8'd128);
            4'd6:    c = mk_rgb(8'd0,   8'd255, 8'd255);
            4'd7:    c = mk_rgb(8'd0,   8'd128, 8'd255);
            4'd8:    c = mk_rgb(8'd0,   8'd0,   8'd255);
            4'd9:    c = mk_rgb(8'd128, 8'd0,   8'd255);
            4'd10:   c = mk_rgb(8'd255, 8'd0,   8'd255);
            4'd11:   c = mk_rgb(8'd255, 8'd0,   8'd128);
            default: c = mk_rgb(8'd0,   8'd0,   8'd0);
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/islsq_cfg.sv =====
module islsq_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [islsq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [islsq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [15:0]                    o_limit,
    output logic [3:0]                     o_sig_idx
);
    import islsq_pkg::*;

    logic [23:0] r_node_id;
    logic [15:0] r_limit;
    logic [3:0]  r_sig_idx;
    logic [3:0]  n_sig_idx;

    logic [13:0] hsum;
    logic [4:0]  pair_sum;
    logic [2:0]  fold3;
    logic [1:0]  m3;
    logic [1:0]  m4;

    assign o_cfg_ready = 1'b1;
    assign o_limit     = r_limit;
    assign o_sig_idx   = r_sig_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id <= '0;
            r_limit   <= LIMIT_RESET;
            r_sig_idx <= '0;
        end else begin
            r_sig_idx <= n_sig_idx;
            if (i_cfg_valid) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_NODE_ID:        r_node_id <= i_cfg_data[23:0];
                    REG_PRESENCE_LIMIT: r_limit   <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // hash mod 12 split into mod 4 (low bits) and mod 3 (sum of base-4 digits)
    always_comb begin
        hsum = 14'(r_node_id[7:0])   * 14'd7
             + 14'(r_node_id[15:8])  * 14'd13
             + 14'(r_node_id[23:16]) * 14'd31;
        pair_sum = '0;
        for (int k = 0; k < 7; k++) begin
            pair_sum = pair_sum + 5'(hsum[2*k +: 2]);
        end
        fold3 = 3'(pair_sum[1:0]) + 3'(pair_sum[3:2]) + 3'(pair_sum[4]);
        if (fold3 >= 3'd6)
            m3 = 2'(fold3 - 3'd6);
        else if (fold3 >= 3'd3)
            m3 = 2'(fold3 - 3'd3);
        else
            m3 = fold3[1:0];
        m4 = hsum[1:0];
        case ({m3, m4})
            4'd0:    n_sig_idx = 4'd0;
            4'd5:    n_sig_idx = 4'd1;
            4'd10:   n_sig_idx = 4'd2;
            4'd3:    n_sig_idx = 4'd3;
            4'd4:    n_sig_idx = 4'd4;
            4'd9:    n_sig_idx = 4'd5;
            4'd2:    n_sig_idx = 4'd6;
            4'd7:    n_sig_idx = 4'd7;
            4'd8:    n_sig_idx = 4'd8;
            4'd1:    n_sig_idx = 4'd9;
            4'd6:    n_sig_idx = 4'd10;
            4'd11:   n_sig_idx = 4'd11;
            default: n_sig_idx = 4'd0;
        endcase
    end

endmodule

// ===== rtl/islsq_front.sv =====
module islsq_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  islsq_pkg::t_item              i_item,
    input  logic [15:0]                   i_limit,
    output logic                          o_valid,
    input  logic                          i_ready,
    output islsq_pkg::t_stage1            o_s1,
    output islsq_pkg::t_front_stat        o_stat
);
    import islsq_pkg::*;

    logic    r_v0;
    t_item   r_item;
    logic    r_v1;
    t_stage1 r_s1;

    logic [31:0] r_salute_start;
    logic        r_was_present;
    logic [31:0] r_blink_start;

    logic [31:0] n_salute_start;
    logic        n_was_present;
    logic [31:0] n_blink_start;
    t_stage1     n_s1;

    logic        rdy1;
    logic        fire0;
    logic [31:0] now_ms;
    logic [31:0] now_nz;
    logic [31:0] since;
    logic [31:0] mp;
    logic        carousel;
    logic        salute;
    logic        track;
    logic        present;
    logic        blink;

    assign rdy1    = !r_v1 || i_ready;
    assign o_ready = !r_v0 || rdy1;
    assign fire0   = r_v0 && rdy1;
    assign o_valid = r_v1;
    assign o_s1    = r_s1;

    assign o_stat.in_valid       = r_v0;
    assign o_stat.advance        = fire0;
    assign o_stat.salute_started = (r_salute_start != '0);

    always_comb begin
        now_ms = r_item.now_ms;
        now_nz = (now_ms == '0) ? 32'd1 : now_ms;

        // zero means unset, so a start at time zero is kept as 1
        n_salute_start = (r_salute_start == '0) ? now_nz : r_salute_start;
        since    = now_ms - n_salute_start;
        carousel = r_item.supply_good && (now_ms < HOUR_MS);
        salute   = !carousel && (since < SALUTE_LEN_MS);
        track    = !carousel && !salute;

        present = (r_item.tof_valid && (r_item.tof_depth_mm != '0)
                   && (r_item.tof_depth_mm < i_limit))
               || (r_item.prox_valid && (r_item.prox_closest_mm != '0)
                   && (r_item.prox_closest_mm < i_limit));

        n_blink_start = (track && present && !r_was_present) ? now_nz : r_blink_start;
        n_was_present = track ? present : r_was_present;
        mp    = now_ms - n_blink_start;
        blink = track && (n_blink_start != '0) && (mp < BLINK_LEN_MS);

        n_s1.car_x  = CAR_X_W'(since[31:16]) * CAR_X_W'(CAR_FOLD)
                    + CAR_X_W'(since[15:0]);
        n_s1.beat_x = BEAT_X_W'(now_ms[31:16]) * BEAT_X_W'(BEAT_FOLD)
                    + BEAT_X_W'(now_ms[15:0]);
        n_s1.fixed  = mk_rgb(8'd0, 8'd0, 8'd0);

        if (carousel) begin
            n_s1.kind = K_CAROUSEL;
        end else if (salute) begin
            n_s1.kind = K_FIXED;
            if (since < SALUTE_STEP_MS)
                n_s1.fixed = mk_rgb(FULL, 8'd0, 8'd0);
            else if (since < (SALUTE_STEP_MS << 1))
                n_s1.fixed = mk_rgb(8'd0, FULL, 8'd0);
            else
                n_s1.fixed = mk_rgb(8'd0, 8'd0, FULL);
        end else if (blink) begin
            n_s1.kind = K_FIXED;
            if (mp < BLINK_SLOT_MS || mp >= BLINK_SLOT2_MS)
                n_s1.fixed = mk_rgb(8'd0, FULL, 8'd0);
            else
                n_s1.fixed = mk_rgb(DIM_RED, 8'd0, 8'd0);
        end else if (present) begin
            n_s1.kind = K_SIGNATURE;
        end else begin
            n_s1.kind = K_BEAT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0           <= 1'b0;
            r_v1           <= 1'b0;
            r_salute_start <= '0;
            r_was_present  <= 1'b0;
            r_blink_start  <= '0;
        end else begin
            if (o_ready)
                r_v0 <= i_valid;
            if (rdy1)
                r_v1 <= r_v0;
            if (fire0) begin
                r_salute_start <= n_salute_start;
                r_was_present  <= n_was_present;
                r_blink_start  <= n_blink_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid)
            r_item <= i_item;
        if (fire0)
            r_s1 <= n_s1;
    end

endmodule

// ===== rtl/islsq_div.sv =====
module islsq_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  islsq_pkg::t_stage1   i_s1,
    output logic                 o_valid,
    input  logic                 i_ready,
    output islsq_pkg::t_stage2   o_s2
);
    import islsq_pkg::*;

    logic               r_v2;
    t_stage2            r_s2;
    t_stage2            n_s2;
    logic [CAR_P_W-1:0]  car_prod;
    logic [BEAT_P_W-1:0] beat_prod;

    assign o_ready = !r_v2 || i_ready;
    assign o_valid = r_v2;
    assign o_s2    = r_s2;

    // quotient by reciprocal multiply, exact over the folded range
    always_comb begin
        car_prod  = CAR_P_W'(i_s1.car_x) * CAR_P_W'(CAR_RECIP);
        beat_prod = BEAT_P_W'(i_s1.beat_x) * BEAT_P_W'(BEAT_RECIP);
        n_s2.kind   = i_s1.kind;
        n_s2.fixed  = i_s1.fixed;
        n_s2.car_x  = i_s1.car_x;
        n_s2.beat_x = i_s1.beat_x;
        n_s2.car_q  = car_prod[CAR_SHIFT +: CAR_Q_W];
        n_s2.beat_q = beat_prod[BEAT_SHIFT +: BEAT_Q_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v2 <= 1'b0;
        else if (o_ready)
            r_v2 <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid)
            r_s2 <= n_s2;
    end

endmodule

// ===== rtl/islsq_back.sv =====
module islsq_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  islsq_pkg::t_stage2   i_s2,
    input  logic [3:0]           i_sig_idx,
    output logic                 o_valid,
    input  logic                 i_ready,
    output islsq_pkg::t_rgb      o_rgb
);
    import islsq_pkg::*;

    logic                r_v3;
    t_rgb                r_rgb;
    t_rgb                n_rgb;
    t_rgb                sig_rgb;
    logic [CAR_X_W-1:0]  car_full;
    logic [BEAT_X_W-1:0] beat_full;
    logic [CAR_R_W-1:0]  car_r;
    logic [BEAT_R_W-1:0] beat_r;
    logic                in_slot;

    assign o_ready = !r_v3 || i_ready;
    assign o_valid = r_v3;
    assign o_rgb   = r_rgb;

    always_comb begin
        car_full  = i_s2.car_x - CAR_X_W'(i_s2.car_q) * CAR_X_W'(CAR_PERIOD);
        beat_full = i_s2.beat_x - BEAT_X_W'(i_s2.beat_q) * BEAT_X_W'(BEAT_PERIOD);
        car_r     = car_full[CAR_R_W-1:0];
        beat_r    = beat_full[BEAT_R_W-1:0];
        sig_rgb   = palette_rgb(i_sig_idx);
        // two signature flashes at the start of each beat period
        in_slot   = (BEAT_R_W'(beat_r) < BEAT_R_W'(BLINK_SLOT_MS))
                 || ((beat_r >= BEAT_R_W'(BLINK_SLOT2_MS))
                     && (beat_r < BEAT_R_W'(BLINK_LEN_MS)));
        case (i_s2.kind)
            K_FIXED: n_rgb = i_s2.fixed;
            K_CAROUSEL: begin
                if (car_r < CAR_R_W'(CAROUSEL_STEP_MS))
                    n_rgb = mk_rgb(FULL, 8'd0, 8'd0);
                else if (car_r < CAR_R_W'(CAROUSEL_STEP_MS << 1))
                    n_rgb = mk_rgb(8'd0, FULL, 8'd0);
                else
                    n_rgb = mk_rgb(8'd0, 8'd0, FULL);
            end
            K_SIGNATURE: n_rgb = sig_rgb;
            K_BEAT: n_rgb = in_slot ? sig_rgb : mk_rgb(DIM_RED, 8'd0, 8'd0);
            default: n_rgb = mk_rgb(8'd0, 8'd0, 8'd0);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v3 <= 1'b0;
        else if (o_ready)
            r_v3 <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid)
            r_rgb <= n_rgb;
    end

endmodule

// ===== rtl/idle_status_light_sequencer.sv =====
// Four register stages (input, decode, reciprocal multiply, colour) carry
// each item to m_axis; each stage holds one item and moves independently.
// Throughput: one item per cycle while m_axis does not stall.
// Reset (i_rst_n low, synchronous): pipeline empty, start and blink times
// cleared, node_id 0, presence limit 1200 mm.
module idle_status_light_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // now_ms[31:0], supply_good[32], tof_valid[33], tof_depth_mm[49:34],
    // prox_valid[50], prox_closest_mm[66:51], zero[71:67]
    input  logic [islsq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic [islsq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [islsq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [islsq_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import islsq_pkg::*;

    logic [15:0]  limit;
    logic [3:0]   sig_idx;
    t_item        in_item;
    t_stage1      s1;
    t_stage2      s2;
    t_rgb         out_rgb;
    t_front_stat  front_stat;
    logic         s1_valid;
    logic         s1_ready;
    logic         s2_valid;
    logic         s2_ready;

    assign in_item      = t_item'(s_axis_tdata[$bits(t_item)-1:0]);
    assign m_axis_tdata = out_rgb;

    islsq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_limit     (limit),
        .o_sig_idx   (sig_idx)
    );

    islsq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_limit (limit),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_s1    (s1),
        .o_stat  (front_stat)
    );

    islsq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_s1    (s1),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_s2    (s2)
    );

    islsq_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s2_valid),
        .o_ready   (s2_ready),
        .i_s2      (s2),
        .i_sig_idx (sig_idx),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_rgb     (out_rgb)
    );

`ifndef SYNTHESIS
    // input back-pressure only when every stage holds an item and the sink stalls
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (front_stat.in_valid && s1_valid && s2_valid
                            && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled with a free stage");

    a_salute_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_stat.advance |=> front_stat.salute_started)
        else $error("start time not latched after an item");

    a_out_from_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s2_valid))
        else $error("result appeared without an item in the multiply stage");
`endif

endmodule
